### hw/rtl/gamepad_deadzone_event_detector_assert.svh
// assertion helpers for the dead-zone event detector checker
`ifndef GAMEPAD_DEADZONE_EVENT_DETECTOR_ASSERT_SVH
`define GAMEPAD_DEADZONE_EVENT_DETECTOR_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define GDZ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define GDZ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/gdz_pkg.sv
package gdz_pkg;

    localparam int NUM_BUTTONS = 15;
    localparam int NUM_AXES    = 6;
    localparam int NUM_STICKS  = 4;
    localparam int NUM_EVENTS  = NUM_BUTTONS + NUM_AXES;
    localparam int EV_IDX_W    = $clog2(NUM_EVENTS);
    localparam int AXIS_IDX_W  = $clog2(NUM_AXES);
    localparam int SRC_W       = 4;
    localparam int AXIS_W      = 16;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 3;
    // queue depth, kept a power of two so the pointers wrap on their own
    localparam int FIFO_DEPTH  = 2;

    localparam logic [KIND_W-1:0] KIND_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AXIS    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STICK_LO   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_HI   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STICK_REST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_REST  = 3'd5;

    localparam logic signed [AXIS_W-1:0] RST_STICK_LO   = 16'shF333;
    localparam logic signed [AXIS_W-1:0] RST_STICK_HI   = 16'sh0CCD;
    localparam logic signed [AXIS_W-1:0] RST_TRIG_LO    = 16'sh8000;
    localparam logic signed [AXIS_W-1:0] RST_TRIG_HI    = 16'sh8666;
    localparam logic signed [AXIS_W-1:0] RST_STICK_REST = 16'sh0000;
    localparam logic signed [AXIS_W-1:0] RST_TRIG_REST  = 16'sh8000;

    typedef struct packed {
        logic signed [AXIS_W-1:0] stick_lo;
        logic signed [AXIS_W-1:0] stick_hi;
        logic signed [AXIS_W-1:0] trig_lo;
        logic signed [AXIS_W-1:0] trig_hi;
        logic signed [AXIS_W-1:0] stick_rest;
        logic signed [AXIS_W-1:0] trig_rest;
    } t_cfg;

    // one classified snapshot: which events fire, and what they report
    typedef struct packed {
        logic [NUM_EVENTS-1:0]              mask;
        logic [NUM_BUTTONS-1:0]             buttons;
        logic [NUM_AXES-1:0][AXIS_W-1:0]    values;
    } t_job;

endpackage

### hw/rtl/gdz_if.sv
interface gdz_in_if import gdz_pkg::*;;
    logic                          valid;
    logic                          ready;
    logic        [NUM_BUTTONS-1:0] buttons;
    logic signed [AXIS_W-1:0]      left_x;
    logic signed [AXIS_W-1:0]      left_y;
    logic signed [AXIS_W-1:0]      right_x;
    logic signed [AXIS_W-1:0]      right_y;
    logic signed [AXIS_W-1:0]      left_pull;
    logic signed [AXIS_W-1:0]      right_pull;

    modport source (output valid, buttons, left_x, left_y, right_x, right_y,
                    left_pull, right_pull, input ready);
    modport sink   (input valid, buttons, left_x, left_y, right_x, right_y,
                    left_pull, right_pull, output ready);
endinterface

interface gdz_out_if import gdz_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic        [KIND_W-1:0] event_kind;
    logic        [SRC_W-1:0]  source_index;
    logic signed [AXIS_W-1:0] axis_value;
    logic                     last_event;

    modport source (output valid, event_kind, source_index, axis_value, last_event,
                    input ready);
    modport sink   (input valid, event_kind, source_index, axis_value, last_event,
                    output ready);
endinterface

interface gdz_cfg_if import gdz_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [AXIS_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/gamepad_deadzone_event_detector.sv
// channel  | dir | payload                                      | transfer when
// ---------+-----+----------------------------------------------+------------------
// i_cfg    | in  | index (3b), data (16b)                       | valid & ready
// i_in     | in  | buttons (15b), six Q1.15 axes                | valid & ready
// o_out    | out | event_kind, source_index, axis_value, last   | valid & ready
//
// a snapshot is classified in the cycle it transfers and queued (two entries)
// the issue stage sends one event per cycle unless o_out stalls, so a snapshot
// sends its n events (1 to 21) in turn; eventless snapshots are never queued
// i_in stalls only while the queue is full; o_out stalls hold the output register
// reset loads the default zones and rest values and resets the history
// config writes transfer every cycle (ready tied high), out-of-range indexes ignored
module gamepad_deadzone_event_detector import gdz_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdz_cfg_if.sink    i_cfg,
    gdz_in_if.sink     i_in,
    gdz_out_if.source  o_out
);

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_head_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stick_lo   <= RST_STICK_LO;
            r_cfg.stick_hi   <= RST_STICK_HI;
            r_cfg.trig_lo    <= RST_TRIG_LO;
            r_cfg.trig_hi    <= RST_TRIG_HI;
            r_cfg.stick_rest <= RST_STICK_REST;
            r_cfg.trig_rest  <= RST_TRIG_REST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_STICK_LO:   r_cfg.stick_lo   <= i_cfg.data;
                REG_STICK_HI:   r_cfg.stick_hi   <= i_cfg.data;
                REG_TRIG_LO:    r_cfg.trig_lo    <= i_cfg.data;
                REG_TRIG_HI:    r_cfg.trig_hi    <= i_cfg.data;
                REG_STICK_REST: r_cfg.stick_rest <= i_cfg.data;
                REG_TRIG_REST:  r_cfg.trig_rest  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    gdz_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    gdz_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    gdz_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_head_job),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

### hw/rtl/gdz_front.sv
module gdz_front import gdz_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    gdz_in_if.sink i_in,
    input  logic   i_full,
    output logic   o_push,
    output t_job   o_job
);

    logic        [NUM_BUTTONS-1:0]          r_prev_btn;
    logic        [NUM_AXES-1:0][AXIS_W-1:0] r_prev_axes;
    logic        [NUM_AXES-1:0]             r_was_dead;
    logic        [NUM_AXES-1:0]             n_was_dead;
    logic signed [AXIS_W-1:0]               w_axis [NUM_AXES];
    logic        [NUM_AXES-1:0]             w_axis_ev;
    logic        [NUM_AXES-1:0][AXIS_W-1:0] w_vals;
    logic                                   w_accept;

    assign w_axis[0] = i_in.left_x;
    assign w_axis[1] = i_in.left_y;
    assign w_axis[2] = i_in.right_x;
    assign w_axis[3] = i_in.right_y;
    assign w_axis[4] = i_in.left_pull;
    assign w_axis[5] = i_in.right_pull;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;

    always_comb begin
        logic signed [AXIS_W-1:0] lo;
        logic signed [AXIS_W-1:0] hi;
        logic signed [AXIS_W-1:0] rest;
        logic                     dead;
        logic                     enter;
        logic                     live;
        for (int a = 0; a < NUM_AXES; a++) begin
            lo    = (a >= NUM_STICKS) ? i_cfg.trig_lo   : i_cfg.stick_lo;
            hi    = (a >= NUM_STICKS) ? i_cfg.trig_hi   : i_cfg.stick_hi;
            rest  = (a >= NUM_STICKS) ? i_cfg.trig_rest : i_cfg.stick_rest;
            dead  = (w_axis[a] >= lo) && (w_axis[a] <= hi);
            enter = !r_was_dead[a] && dead;
            live  = !dead && (w_axis[a] != $signed(r_prev_axes[a]));
            w_axis_ev[a] = enter || live;
            w_vals[a]    = enter ? rest : w_axis[a];
            if (enter) begin
                n_was_dead[a] = 1'b1;
            end else if (live) begin
                n_was_dead[a] = 1'b0;
            end else begin
                n_was_dead[a] = r_was_dead[a];
            end
        end
    end

    assign o_job.mask    = {w_axis_ev, i_in.buttons ^ r_prev_btn};
    assign o_job.buttons = i_in.buttons;
    assign o_job.values  = w_vals;
    // a quiet snapshot only updates the history
    assign o_push        = w_accept && (o_job.mask != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_btn  <= '0;
            r_prev_axes <= '0;
            r_was_dead  <= '1;
        end else if (w_accept) begin
            r_prev_btn <= i_in.buttons;
            r_was_dead <= n_was_dead;
            for (int a = 0; a < NUM_AXES; a++) begin
                r_prev_axes[a] <= w_axis[a];
            end
        end
    end

endmodule

### hw/rtl/gdz_fifo.sv
module gdz_fifo import gdz_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    t_job             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hw/rtl/gdz_back.sv
module gdz_back import gdz_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_job,
    input  logic        i_empty,
    output logic        o_pop,
    gdz_out_if.source   o_out
);

    logic        [NUM_EVENTS-1:0]           r_mask;
    logic        [NUM_BUTTONS-1:0]          r_btn;
    logic        [NUM_AXES-1:0][AXIS_W-1:0] r_vals;
    logic                                   r_out_valid;
    logic        [KIND_W-1:0]               r_kind;
    logic        [SRC_W-1:0]                r_src;
    logic signed [AXIS_W-1:0]               r_value;
    logic                                   r_last;

    logic        [NUM_EVENTS-1:0]           w_low;
    logic        [NUM_EVENTS-1:0]           w_rest;
    logic        [NUM_EVENTS-1:0]           w_mask_after;
    logic        [EV_IDX_W-1:0]             w_idx;
    logic        [AXIS_IDX_W-1:0]           w_axis_idx;
    logic                                   w_advance;
    logic                                   w_emit;
    logic                                   w_load;
    logic        [KIND_W-1:0]               n_kind;
    logic        [SRC_W-1:0]                n_src;
    logic signed [AXIS_W-1:0]               n_value;

    assign w_advance    = !r_out_valid || o_out.ready;
    assign w_emit       = w_advance && (r_mask != '0);
    assign w_low        = r_mask & (~r_mask + 1'b1);
    assign w_rest       = r_mask & ~w_low;
    assign w_mask_after = w_emit ? w_rest : r_mask;
    // next snapshot slides in as the current one issues its final event
    assign w_load       = (w_mask_after == '0) && !i_empty;
    assign o_pop        = w_load;

    always_comb begin
        w_idx = '0;
        for (int i = NUM_EVENTS - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                w_idx = EV_IDX_W'(i);
            end
        end
    end

    assign w_axis_idx = AXIS_IDX_W'(w_idx - EV_IDX_W'(NUM_BUTTONS));

    always_comb begin
        if (w_idx < EV_IDX_W'(NUM_BUTTONS)) begin
            n_kind  = r_btn[w_idx[SRC_W-1:0]] ? KIND_PRESS : KIND_RELEASE;
            n_src   = w_idx[SRC_W-1:0];
            n_value = '0;
        end else begin
            n_kind  = KIND_AXIS;
            n_src   = SRC_W'(w_axis_idx);
            n_value = r_vals[w_axis_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= w_load ? i_job.mask : w_mask_after;
            if (w_advance) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_btn  <= i_job.buttons;
            r_vals <= i_job.values;
        end
        if (w_emit) begin
            r_kind  <= n_kind;
            r_src   <= n_src;
            r_value <= n_value;
            r_last  <= (w_rest == '0);
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_kind   = r_kind;
    assign o_out.source_index = r_src;
    assign o_out.axis_value   = r_value;
    assign o_out.last_event   = r_last;

endmodule

### hw/rtl/gdz_checker.sv
`include "gamepad_deadzone_event_detector_assert.svh"

module gdz_checker import gdz_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic        [KIND_W-1:0] i_out_kind,
    input logic        [SRC_W-1:0]  i_out_src,
    input logic signed [AXIS_W-1:0] i_out_value,
    input logic                     i_out_last
);

    // a stalled event keeps its contents
    `GDZ_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_kind) && $stable(i_out_src) && $stable(i_out_value) && $stable(i_out_last), "stalled event changed")

    `GDZ_ASSERT_NOW(a_button_value_zero, i_out_valid && (i_out_kind != KIND_AXIS), i_out_value == '0, "button event carries a nonzero value")

    `GDZ_ASSERT_NOW(a_axis_src_range, i_out_valid && (i_out_kind == KIND_AXIS), i_out_src < SRC_W'(NUM_AXES), "axis event with bad axis index")

    `GDZ_ASSERT_NOW(a_button_src_range, i_out_valid && (i_out_kind != KIND_AXIS), i_out_src < SRC_W'(NUM_BUTTONS), "button event with bad button index")

endmodule

bind gamepad_deadzone_event_detector gdz_checker u_gdz_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.event_kind),
    .i_out_src   (o_out.source_index),
    .i_out_value (o_out.axis_value),
    .i_out_last  (o_out.last_event)
);
